// ===== src/framed_setpoint_command_parser_unit_assert.svh =====
// assertion macros used by the parser top level
`ifndef FRAMED_SETPOINT_COMMAND_PARSER_UNIT_ASSERT_SVH
`define FRAMED_SETPOINT_COMMAND_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FSCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fscp_pkg.sv =====
package fscp_pkg;

	// framing bytes
	localparam logic [7:0] CH_START = 8'h78;
	localparam logic [7:0] CH_END   = 8'h79;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// keyword geometry
	localparam int KW_COUNT = 7;
	localparam int KW_LEN   = 8;

	// keyword table, one row per setpoint
	localparam logic [7:0] KEYWORDS [KW_COUNT][KW_LEN] = '{
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h74, 8'h65, 8'h6D, 8'h70},  // setpoint 0
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h66, 8'h6F, 8'h74, 8'h31},  // setpoint 1
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h66, 8'h6F, 8'h74, 8'h32},  // setpoint 2
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h73, 8'h76, 8'h6A, 8'h65},  // setpoint 3
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h67, 8'h72, 8'h69, 8'h6A},  // setpoint 4
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h73, 8'h61, 8'h74, 8'h69},  // setpoint 5
		'{8'h7A, 8'h61, 8'h64, 8'h5F, 8'h6D, 8'h69, 8'h6E, 8'h75}   // setpoint 6
	};

	// result codes
	typedef enum logic [1:0] {
		OUT_STORED   = 2'd0,
		OUT_UNKNOWN  = 2'd1,
		OUT_OVERFLOW = 2'd2
	} outcome_t;

	// number scanner phases
	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// one result word
	typedef struct packed {
		logic [15:0] setpoint_value;
		logic [2:0]  setpoint_index;
		outcome_t    outcome;
	} result_t;

endpackage

// ===== src/framed_setpoint_command_parser_unit.sv =====
// framed setpoint command parser
// input stream: one received serial byte per word on s_tdata[7:0]
// bytes before an 'x' are dropped; bytes up to the closing 'y' form the body
// body chars 1..8 select one of seven keywords, char 9 is skipped, char 10 on
// is read as a decimal number with optional whitespace and sign
// output stream: one word per closed non-empty frame, carrying outcome,
// setpoint index and the value (zero unless the setpoint was stored)
// throughput: one byte per cycle unless a closing byte waits on a full result
// register; each byte passes one input register and one combinational parse
// step into the result register
// reset: clears the frame state to waiting for 'x' and empties both registers
// stall: while a result waits on m_tready, bytes are still taken into the
// input register; bytes that close no frame keep flowing, and a closing byte
// holds the input side until the result register drains
module framed_setpoint_command_parser_unit #(
	parameter int BUFFER_SIZE = 80,
	parameter int VALUE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // outcome[1:0], setpoint_index[4:2], setpoint_value[20:5]
);
	import fscp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance, produce, out_free;
	logic       word_stored;
	result_t    result;

	// stage 1 moves on unless it closes a frame into a full result slot
	assign advance  = valid_s1 && (!produce || out_free);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	fscp_parse #(
		.BUFFER_SIZE(BUFFER_SIZE),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (valid_s1),
		.en      (advance),
		.rx_byte (byte_s1),
		.produce (produce),
		.result  (result)
	);

	fscp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && produce),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// outgoing word reports a stored setpoint
	assign word_stored = (m_tdata[1:0] == OUT_STORED);

	`include "framed_setpoint_command_parser_unit_assert.svh"

	`FSCP_ASSERT_NEXT(a_result_lands, advance && produce, m_tvalid, "closed frame lost its result")
	`FSCP_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "byte lost")
	`FSCP_ASSERT_NOW(a_value_zero, m_tvalid && !word_stored, m_tdata[20:2] == '0, "stray value")
	`FSCP_ASSERT_NOW(a_no_idle_result, !valid_s1, !produce, "result without a byte")

endmodule

// ===== src/fscp_parse.sv =====
module fscp_parse #(
	parameter int BUFFER_SIZE = 80,
	parameter int VALUE_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  logic            en,
	input  logic [7:0]      rx_byte,
	output logic            produce,
	output fscp_pkg::result_t result
);
	import fscp_pkg::*;

	localparam int PW = $clog2(BUFFER_SIZE + 1);
	localparam logic [PW-1:0] BUF_LIMIT = PW'(BUFFER_SIZE);
	localparam logic [PW-1:0] POS_KW    = PW'(KW_LEN);

	logic                   in_frame_q, in_frame_d;
	logic [PW-1:0]          pos_q, pos_d;
	logic [KW_COUNT-1:0]    cand_q, cand_d;
	phase_t                 phase_q, phase_d;
	logic                   neg_q, neg_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;

	logic [KW_COUNT-1:0]    match;
	logic                   is_digit, is_space, is_sign;
	logic [VALUE_WIDTH-1:0] acc_step, acc_signed;
	logic [31:0]            value_wide;
	logic [2:0]             idx;

	// per-keyword compare of the current character
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			match[k] = (KEYWORDS[k][pos_q[2:0]] == rx_byte);
		end
	end

	// character classes and decimal step
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
	assign acc_step = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(rx_byte[3:0]);

	// signed value, zero-extended then cut to the reported width
	assign acc_signed = neg_q ? (VALUE_WIDTH'(0) - acc_q) : acc_q;
	assign value_wide = 32'(acc_signed);

	// lowest surviving keyword wins
	always_comb begin
		idx = 3'd0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand_q[k]) idx = 3'(k);
		end
	end

	// frame state and result
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		cand_d     = cand_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		produce    = 1'b0;
		result     = '0;
		// closing byte of a non-empty body yields one word
		if (valid && in_frame_q && (rx_byte == CH_END) && (pos_q != '0)) begin
			produce = 1'b1;
			if (pos_q >= BUF_LIMIT) begin
				result.outcome = OUT_OVERFLOW;
			end else if ((pos_q < POS_KW) || (cand_q == '0)) begin
				result.outcome = OUT_UNKNOWN;
			end else begin
				result.outcome        = OUT_STORED;
				result.setpoint_index = idx;
				result.setpoint_value = value_wide[15:0];
			end
		end
		if (en) begin
			if (!in_frame_q) begin
				if (rx_byte == CH_START) in_frame_d = 1'b1;
			end else if (rx_byte != CH_END) begin
				if (pos_q < POS_KW) begin
					cand_d = cand_q & match;
				end else if ((pos_q > POS_KW) && (pos_q < BUF_LIMIT)) begin
					case (phase_q)
						PH_DONE: ;
						PH_SPACE: begin
							if (is_sign) begin
								neg_d   = (rx_byte == CH_MINUS);
								phase_d = PH_SIGN;
							end else if (is_digit) begin
								acc_d   = acc_step;
								phase_d = PH_DIGITS;
							end else if (!is_space) begin
								phase_d = PH_DONE;
							end
						end
						default: begin
							if (is_digit) begin
								acc_d   = acc_step;
								phase_d = PH_DIGITS;
							end else begin
								phase_d = PH_DONE;
							end
						end
					endcase
				end
				if (pos_q < BUF_LIMIT) pos_d = pos_q + PW'(1);
			end else begin
				// closing byte: start over
				in_frame_d = 1'b0;
				pos_d      = '0;
				cand_d     = '1;
				phase_d    = PH_SPACE;
				neg_d      = 1'b0;
				acc_d      = '0;
			end
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			cand_q     <= '1;
			phase_q    <= PH_SPACE;
			neg_q      <= 1'b0;
			acc_q      <= '0;
		end else begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			cand_q     <= cand_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
		end
	end

endmodule

// ===== src/fscp_out_reg.sv =====
module fscp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fscp_pkg::result_t result,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata   // outcome[1:0], setpoint_index[4:2], setpoint_value[20:5]
);
	import fscp_pkg::*;

	logic    valid_q;
	result_t data_q;

	// slot can take a new word when empty or being drained
	assign free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (free && load) data_q <= result;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {3'b000, data_q};

endmodule

// ===== tb/sv/setpoint_result_checker.sv =====
// watches both streams, predicts the parser results and compares them
module setpoint_result_checker #(
	parameter int BUFFER_SIZE = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // outcome[1:0], setpoint_index[4:2], setpoint_value[20:5]
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import fscp_pkg::*;

	// predicted parser state
	logic                framing;
	int unsigned         body_len;
	logic [KW_COUNT-1:0] still_match;
	phase_t              scan_phase;
	logic                minus;
	logic [15:0]         acc;
	logic [15:0]         setpoints [KW_COUNT];

	result_t results_due [$];
	int      mismatches;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic restart_frame();
		framing     = 1'b0;
		body_len    = 0;
		still_match = '1;
		scan_phase  = PH_SPACE;
		minus       = 1'b0;
		acc         = '0;
	endtask

	// atoi-style scan of the value text, wrapping at 16 bits
	task automatic scan_number(input logic [7:0] c);
		if (scan_phase == PH_DONE) begin
		end else if (scan_phase == PH_SPACE && is_blank(c)) begin
		end else if (scan_phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
			minus      = (c == CH_MINUS);
			scan_phase = PH_SIGN;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			acc        = 16'(acc * 16'd10 + 16'(c - CH_ZERO));
			scan_phase = PH_DIGITS;
		end else begin
			scan_phase = PH_DONE;
		end
	endtask

	// one accepted byte; a closing byte of a non-empty body queues a result
	task automatic take_byte(input logic [7:0] c);
		result_t     r;
		int          sel;
		logic [15:0] val;
		if (!framing) begin
			if (c == CH_START)
				framing = 1'b1;
		end else if (c != CH_END) begin
			if (body_len < KW_LEN) begin
				for (int k = 0; k < KW_COUNT; k++)
					if (KEYWORDS[k][body_len] != c)
						still_match[k] = 1'b0;
			end else if (body_len > KW_LEN && body_len < BUFFER_SIZE) begin
				scan_number(c);
			end
			if (body_len < BUFFER_SIZE)
				body_len++;
		end else begin
			if (body_len != 0) begin
				r = '0;
				if (body_len > BUFFER_SIZE - 1) begin
					r.outcome = OUT_OVERFLOW;
				end else if (body_len < KW_LEN || still_match == '0) begin
					r.outcome = OUT_UNKNOWN;
				end else begin
					sel = 0;
					for (int k = KW_COUNT - 1; k >= 0; k--)
						if (still_match[k])
							sel = k;
					val = minus ? 16'(-acc) : acc;
					setpoints[sel]   = val;
					r.outcome        = OUT_STORED;
					r.setpoint_index = 3'(sel);
					r.setpoint_value = val;
				end
				results_due.push_back(r);
			end
			restart_frame();
		end
	endtask

	task automatic complain(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected outcome %0d index %0d value %0d,",
				$realtime, what, want.outcome, want.setpoint_index,
				$signed(want.setpoint_value),
				" got outcome %0d index %0d value %0d",
				got.outcome, got.setpoint_index, $signed(got.setpoint_value));
	endtask

	// compare one result word with the oldest prediction
	task automatic check_result(input result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			complain("unexpected result", '0, got);
		end else begin
			want = results_due.pop_front();
			if (got.outcome != want.outcome || got.setpoint_index != want.setpoint_index ||
				got.setpoint_value != want.setpoint_value)
				complain("result mismatch", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_frame();
			for (int k = 0; k < KW_COUNT; k++)
				setpoints[k] = '0;
			results_due.delete();
			mismatches = 0;
		end else begin
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata[20:0]));
		end
		fail_count  <= mismatches;
		outstanding <= results_due.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// stimulus, flow control and verdict for the setpoint command parser
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fscp_pkg::*;

	localparam int BUF_LEN     = 80;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 640;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int send_idle = 14;
	int recv_idle = 56;
	int hold_asks = 0;
	int bytes_sent = 0;
	int stall_cycles = 0;
	int fail_count;
	int outstanding;

	framed_setpoint_command_parser_unit #(
		.BUFFER_SIZE(BUF_LEN),
		.VALUE_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	setpoint_result_checker #(
		.BUFFER_SIZE(BUF_LEN)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial forever #1 clk = ~clk;

	// cycles without any word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random ready, plus a long hold-off whenever one is asked for
	initial begin : ready_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// offer one byte, with random gaps, until the word is taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// any byte that does not close the frame
	function automatic logic [7:0] body_char();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_END)
			b = CH_START;
		return b;
	endfunction

	task automatic send_keyword(input int k);
		for (int i = 0; i < KW_LEN; i++)
			send_byte(KEYWORDS[k][i]);
	endtask

	// whitespace, sign, digits and trailing junk after the skipped char
	task automatic send_value_text();
		int sign_pick;
		int blanks;
		int w;
		blanks = $urandom_range(2);
		for (int i = 0; i < blanks; i++) begin
			w = $urandom_range(5);
			send_byte(w == 5 ? CH_SPACE : CH_TAB + 8'(w));
		end
		sign_pick = $urandom_range(5);
		if (sign_pick == 2 || sign_pick == 5)
			send_byte(CH_PLUS);
		if (sign_pick >= 3)
			send_byte(CH_MINUS);
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(4))
				0: send_text("32767");
				1: send_text("32768");
				2: send_text("65535");
				3: send_text("65536");
				default: send_text("0");
			endcase
		end else begin
			repeat ($urandom_range(6))
				send_byte(CH_ZERO + 8'($urandom_range(9)));
		end
		repeat ($urandom_range(3))
			send_byte(body_char());
	endtask

	// one frame: optional noise, start, body of a random kind, end
	task automatic send_command_frame();
		int kind;
		int k;
		int len;
		int bad_pos;
		kind = $urandom_range(99);
		k    = $urandom_range(KW_COUNT - 1);
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				logic [7:0] n;
				n = 8'($urandom_range(255));
				send_byte(n == CH_START ? CH_END : n);
			end
		end
		send_byte(CH_START);
		if (kind < 70) begin
			// well-formed command, sometimes cut after the keyword or the skipped char
			send_keyword(k);
			if ($urandom_range(9) != 0) begin
				send_byte(body_char());
				if ($urandom_range(9) != 0)
					send_value_text();
			end
		end else if (kind < 85) begin
			// keyword with one corrupted char
			bad_pos = $urandom_range(KW_LEN - 1);
			for (int i = 0; i < KW_LEN; i++)
				send_byte(i == bad_pos ? body_char() : KEYWORDS[k][i]);
			send_byte(body_char());
			send_value_text();
		end else if (kind < 93) begin
			// short or empty body, often a keyword prefix
			len = $urandom_range(KW_LEN - 1);
			for (int i = 0; i < len; i++)
				send_byte($urandom_range(1) ? KEYWORDS[k][i] : body_char());
		end else if (kind < 96) begin
			// long body around the buffer limit
			len = $urandom_range(BUF_LEN - 5, BUF_LEN + 15);
			send_keyword(k);
			for (int i = KW_LEN; i < len; i++)
				send_byte(body_char());
		end else begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				send_byte(body_char());
		end
		send_byte(CH_END);
	endtask

	task automatic run_random(input int count, input logic ask_hold);
		int stop_at;
		logic asked;
		stop_at = bytes_sent + count;
		asked   = 1'b0;
		while (bytes_sent < stop_at) begin
			if (ask_hold && !asked && bytes_sent > stop_at - count / 2) begin
				hold_asks++;
				asked = 1'b1;
			end
			send_command_frame();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle noise with byte extremes, empty body, short body
		// with nul and 0xff, bare keyword, 'x' as the skipped char
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_END);
		send_byte(CH_START);
		send_byte(CH_END);
		send_byte(CH_START);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_END);
		send_byte(CH_START);
		send_keyword(KW_COUNT - 1);
		send_byte(CH_END);
		send_byte(CH_START);
		send_keyword(1);
		send_byte(CH_START);
		send_text("-5");
		send_byte(CH_END);

		run_random(PHASE_BYTES, 1'b1);
		send_idle = 56;
		recv_idle = 14;
		run_random(PHASE_BYTES, 1'b1);
		send_idle = 0;
		recv_idle = 0;
		run_random(PHASE_BYTES, 1'b0);
		s_tvalid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/fscp_pkg.sv
src/fscp_parse.sv
src/fscp_out_reg.sv
src/framed_setpoint_command_parser_unit.sv
tb/sv/setpoint_result_checker.sv
tb/sv/tb.sv
